@@ rtl/u8d_pkg.sv @@
package u8d_pkg;

    // result kinds
    localparam logic [1:0] KIND_VALID   = 2'd0;
    localparam logic [1:0] KIND_BROKEN  = 2'd1;
    localparam logic [1:0] KIND_BADLEAD = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // result queue geometry (power of two)
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = RQ_PTR_W + 1;

    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  kind;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]  num;        // results produced by this beat, 0 to 2
        result_t     res0;
        result_t     res1;
        logic [30:0] partial_next;
        logic [2:0]  pending_next;
    } step_t;

endpackage

@@ rtl/utf8_stream_decoder_core.sv @@
// utf8 stream decoder: turns a utf-8 byte stream into code points
// input channel: data_byte / end_marker with in_valid / in_ready, one byte per beat;
//   end_marker closes the string and flushes an open sequence as broken
// output channel: code_point / kind / last_of_run with out_valid / out_ready;
//   kind 0 valid character, 1 broken sequence, 2 invalid lead byte;
//   last_of_run marks the final result caused by one input beat
// a byte beat gives 0, 1 or 2 results (two when a sequence is interrupted
//   and the interrupting byte is itself a complete character or a bad lead)
// path: a beat lands in the input register, is decoded combinationally from there when
//   the queue has room, and its results go into the result queue that drives out_valid
// throughput: one input beat per cycle while the receiver keeps up; a beat that
//   yields two results is absorbed by a four-entry result queue that only takes
//   a decode when it has room for two results
// receiver stall: the queue fills, the decode stage holds, then in_ready drops;
//   nothing is lost or repeated
// reset: asynchronous active low; clears the open sequence, the input stage and
//   the result queue, so no sequence is open afterwards
module utf8_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        end_marker,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] code_point,
    output logic [1:0]  kind,
    output logic        last_of_run,
    output logic        out_valid,
    input  logic        out_ready
);

    // input register
    logic        in_full_reg, in_full_next;
    logic [7:0]  byte_reg;
    logic        end_reg;

    // decoder state: partial code point and continuation bytes still due
    logic [30:0] partial_reg, partial_next;
    logic [2:0]  pending_reg, pending_next;

    u8d_pkg::step_t   step;
    u8d_pkg::result_t head;
    logic             room_two;
    logic             fire;
    logic             take_in;
    logic [1:0]       wr_num;

    // decode fires when a byte is held and the queue can absorb two results
    assign fire     = in_full_reg && room_two;
    assign in_ready = !in_full_reg || fire;
    assign take_in  = in_valid && in_ready;
    assign wr_num   = fire ? step.num : 2'd0;

    assign in_full_next = take_in || (in_full_reg && !fire);
    assign partial_next = fire ? step.partial_next : partial_reg;
    assign pending_next = fire ? step.pending_next : pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            partial_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= data_byte;
            end_reg  <= end_marker;
        end
    end

    u8d_decode u_decode
    (
        .data_byte  (byte_reg),
        .end_marker (end_reg),
        .partial    (partial_reg),
        .pending    (pending_reg),
        .step       (step)
    );

    u8d_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_num   (wr_num),
        .wr_res0  (step.res0),
        .wr_res1  (step.res1),
        .room_two (room_two),
        .rd_valid (out_valid),
        .rd_take  (out_ready),
        .rd_res   (head)
    );

    assign code_point  = head.code_point;
    assign kind        = head.kind;
    assign last_of_run = head.last_of_run;

endmodule

@@ rtl/u8d_decode.sv @@
module u8d_decode
(
    input  logic [7:0]       data_byte,
    input  logic             end_marker,
    input  logic [30:0]      partial,
    input  logic [2:0]       pending,
    output u8d_pkg::step_t   step
);

    logic        lead_has_res;
    logic [31:0] lead_cp;
    logic [1:0]  lead_kind;
    logic [30:0] lead_partial;
    logic [2:0]  lead_pending;
    logic [30:0] shifted;
    logic        is_cont;

    // lead byte classification with no sequence open
    always_comb
    begin
        lead_has_res = 1'b0;
        lead_cp      = 32'd0;
        lead_kind    = u8d_pkg::KIND_VALID;
        lead_partial = 31'd0;
        lead_pending = 3'd0;
        priority if (data_byte[7] == 1'b0)
        begin
            lead_has_res = 1'b1;
            lead_cp      = {24'd0, data_byte};
        end
        else if ((data_byte & 8'hE0) == 8'hC0)
        begin
            lead_partial = {26'd0, data_byte[4:0]};
            lead_pending = 3'd1;
        end
        else if ((data_byte & 8'hF0) == 8'hE0)
        begin
            lead_partial = {27'd0, data_byte[3:0]};
            lead_pending = 3'd2;
        end
        else if ((data_byte & 8'hF8) == 8'hF0)
        begin
            lead_partial = {28'd0, data_byte[2:0]};
            lead_pending = 3'd3;
        end
        else if ((data_byte & 8'hFC) == 8'hF8)
        begin
            lead_partial = {29'd0, data_byte[1:0]};
            lead_pending = 3'd4;
        end
        else if ((data_byte & 8'hFE) == 8'hFC)
        begin
            lead_partial = {30'd0, data_byte[0]};
            lead_pending = 3'd5;
        end
        else
        begin
            lead_has_res = 1'b1;
            lead_kind    = u8d_pkg::KIND_BADLEAD;
        end
    end

    assign is_cont = (data_byte & 8'hC0) == 8'h80;
    assign shifted = {partial[24:0], data_byte[5:0]};

    always_comb
    begin
        step = '0;
        step.partial_next = partial;
        step.pending_next = pending;
        priority if (end_marker)
        begin
            // flush an open sequence as broken
            step.partial_next = 31'd0;
            step.pending_next = 3'd0;
            if (pending != 3'd0)
            begin
                step.num  = 2'd1;
                step.res0 = '{code_point: u8d_pkg::ALL_ONES,
                              kind: u8d_pkg::KIND_BROKEN, last_of_run: 1'b1};
            end
        end
        else if (pending != 3'd0 && is_cont)
        begin
            step.pending_next = pending - 3'd1;
            step.partial_next = shifted;
            if (pending == 3'd1)
            begin
                step.num          = 2'd1;
                step.res0         = '{code_point: {1'b0, shifted},
                                      kind: u8d_pkg::KIND_VALID, last_of_run: 1'b1};
                step.partial_next = 31'd0;
            end
        end
        else if (pending != 3'd0)
        begin
            // interrupted sequence, then the byte starts over as a lead
            step.res0 = '{code_point: u8d_pkg::ALL_ONES,
                          kind: u8d_pkg::KIND_BROKEN, last_of_run: !lead_has_res};
            step.res1 = '{code_point: lead_cp, kind: lead_kind, last_of_run: 1'b1};
            step.num  = lead_has_res ? 2'd2 : 2'd1;
            step.partial_next = lead_partial;
            step.pending_next = lead_pending;
        end
        else
        begin
            step.res0 = '{code_point: lead_cp, kind: lead_kind, last_of_run: 1'b1};
            step.num  = lead_has_res ? 2'd1 : 2'd0;
            step.partial_next = lead_partial;
            step.pending_next = lead_pending;
        end
    end

endmodule

@@ rtl/u8d_result_queue.sv @@
module u8d_result_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         wr_num,
    input  u8d_pkg::result_t   wr_res0,
    input  u8d_pkg::result_t   wr_res1,
    output logic               room_two,
    output logic               rd_valid,
    input  logic               rd_take,
    output u8d_pkg::result_t   rd_res
);

    u8d_pkg::result_t                 mem_reg [u8d_pkg::RQ_DEPTH];
    logic [u8d_pkg::RQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [u8d_pkg::RQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [u8d_pkg::RQ_CNT_W-1:0]     count_reg, count_next;
    logic [u8d_pkg::RQ_PTR_W-1:0]     wr_ptr_inc;
    logic                             pop;

    assign pop        = rd_take && rd_valid;
    assign wr_ptr_inc = wr_ptr_reg + u8d_pkg::RQ_PTR_W'(1);
    assign rd_valid   = count_reg != '0;
    assign rd_res     = mem_reg[rd_ptr_reg];
    assign room_two   = count_reg <= u8d_pkg::RQ_CNT_W'(u8d_pkg::RQ_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + u8d_pkg::RQ_PTR_W'(wr_num);
    assign rd_ptr_next = rd_ptr_reg + u8d_pkg::RQ_PTR_W'(pop);
    assign count_next  = count_reg + u8d_pkg::RQ_CNT_W'(wr_num)
                         - u8d_pkg::RQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_res0;
        end
        if (wr_num == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= wr_res1;
        end
    end

endmodule

@@ bench/tb_utf8_stream_decoder_core.sv @@
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_core;

    localparam logic TYPED = 1'b1;   // row carries its own expected results
    localparam logic PRED  = 1'b0;   // row is checked against the decode predictor
    localparam int   RANDOM_BEATS = 1750;
    localparam int   TAIL_CYCLES  = 8;

    localparam logic [1:0]  K_VALID   = u8d_pkg::KIND_VALID;
    localparam logic [1:0]  K_BROKEN  = u8d_pkg::KIND_BROKEN;
    localparam logic [1:0]  K_BADLEAD = u8d_pkg::KIND_BADLEAD;
    localparam logic [31:0] ONES      = u8d_pkg::ALL_ONES;

    // one row of the directed table
    typedef struct packed {
        logic [7:0]  b;
        logic        e;
        logic        typed;
        logic [1:0]  nres;
        logic [31:0] cp0;
        logic [1:0]  k0;
        logic [31:0] cp1;
        logic [1:0]  k1;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        end_marker = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] code_point;
    logic [1:0]  kind;
    logic        last_of_run;
    logic        out_valid;
    logic        out_ready = 1'b0;

    // decoder shadow state
    logic [30:0] acc_bits = 31'd0;
    logic [2:0]  conts_due = 3'd0;

    u8d_pkg::result_t code_points_due [$];
    int          mismatches = 0;
    int          in_gap_max = 3;
    int          out_stall_max = 3;
    dir_row_t    dir_rows [24];

    always #10 clk = ~clk;

    utf8_stream_decoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .end_marker  (end_marker),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_point  (code_point),
        .kind        (kind),
        .last_of_run (last_of_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    // byte seen with no sequence open; returns 1 when it gives a result
    function automatic bit lead_step(input logic [7:0] b, output u8d_pkg::result_t r);
        r = {32'd0, K_BADLEAD, 1'b0};
        lead_step = 1'b1;
        if (!b[7])
        begin
            r = {24'd0, b, K_VALID, 1'b0};
        end
        else if (b[7:5] == 3'b110)
        begin
            acc_bits  = {26'd0, b[4:0]};
            conts_due = 3'd1;
            lead_step = 1'b0;
        end
        else if (b[7:4] == 4'b1110)
        begin
            acc_bits  = {27'd0, b[3:0]};
            conts_due = 3'd2;
            lead_step = 1'b0;
        end
        else if (b[7:3] == 5'b11110)
        begin
            acc_bits  = {28'd0, b[2:0]};
            conts_due = 3'd3;
            lead_step = 1'b0;
        end
        else if (b[7:2] == 6'b111110)
        begin
            acc_bits  = {29'd0, b[1:0]};
            conts_due = 3'd4;
            lead_step = 1'b0;
        end
        else if (b[7:1] == 7'b1111110)
        begin
            acc_bits  = {30'd0, b[0]};
            conts_due = 3'd5;
            lead_step = 1'b0;
        end
    endfunction

    // advance the shadow decoder by one beat, returns the number of results
    function automatic int decode_step(input logic [7:0] b, input logic e,
                                       output u8d_pkg::result_t r0,
                                       output u8d_pkg::result_t r1);
        u8d_pkg::result_t got;
        int      n;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (e)
        begin
            // end of string flushes an open sequence
            if (conts_due != 3'd0)
            begin
                r0 = {ONES, K_BROKEN, 1'b0};
                n  = 1;
            end
            acc_bits  = 31'd0;
            conts_due = 3'd0;
        end
        else if (conts_due != 3'd0 && b[7:6] == 2'b10)
        begin
            acc_bits  = {acc_bits[24:0], b[5:0]};
            conts_due = conts_due - 3'd1;
            if (conts_due == 3'd0)
            begin
                r0 = {1'b0, acc_bits, K_VALID, 1'b0};
                n  = 1;
                acc_bits = 31'd0;
            end
        end
        else
        begin
            // interrupted sequence: report it, then treat the byte as a lead
            if (conts_due != 3'd0)
            begin
                r0 = {ONES, K_BROKEN, 1'b0};
                n  = 1;
                acc_bits  = 31'd0;
                conts_due = 3'd0;
            end
            if (lead_step(b, got))
            begin
                if (n == 0)
                    r0 = got;
                else
                    r1 = got;
                n++;
            end
        end
        if (n == 1)
            r0.last_of_run = 1'b1;
        if (n == 2)
            r1.last_of_run = 1'b1;
        return n;
    endfunction

    function automatic void push_due(input logic [31:0] cp, input logic [1:0] k,
                                     input logic last);
        u8d_pkg::result_t r;
        r = {cp, k, last};
        code_points_due.push_back(r);
    endfunction

    // random lead byte of a given sequence length
    function automatic logic [7:0] lead_for(input int len);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case (len)
            1: b[7]   = 1'b0;
            2: b[7:5] = 3'b110;
            3: b[7:4] = 4'b1110;
            4: b[7:3] = 5'b11110;
            5: b[7:2] = 6'b111110;
            default: b[7:1] = 7'b1111110;
        endcase
        return b;
    endfunction

    // present one beat after a random gap; returns at the accepting edge
    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= b;
        end_marker <= e;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold the sender off until every due result has come out
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (code_points_due.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall ahead of every result beat
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // result checker, oldest expectation first
    always @(posedge clk)
    begin : watch_results
        u8d_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (code_points_due.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got cp=%h kind=%0d last=%0b",
                         $time, code_point, kind, last_of_run);
                mismatches++;
            end
            else
            begin
                want = code_points_due.pop_front();
                if (code_point !== want.code_point)
                begin
                    $display("%0t: code_point expected %h, got %h",
                             $time, want.code_point, code_point);
                    mismatches++;
                end
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
                    mismatches++;
                end
                if (last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, want.last_of_run, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        u8d_pkg::result_t r0;
        u8d_pkg::result_t r1;
        int         n;
        int         rand_beats;
        int         sel;
        int         len;
        bit         paused;
        logic [7:0] b;
        logic [8:0] burst [$];
        logic [8:0] beat;

        // directed rows: ascii extremes, bad leads, two-, three- and six-byte sequences,
        // interruptions and the end marker with and without an open sequence
        dir_rows = '{
            '{8'h00, 1'b0, TYPED, 2'd1, 32'h0000_0000, K_VALID,   32'd0,  K_VALID},
            '{8'h7F, 1'b0, TYPED, 2'd1, 32'h0000_007F, K_VALID,   32'd0,  K_VALID},
            '{8'hFF, 1'b0, TYPED, 2'd1, 32'h0000_0000, K_BADLEAD, 32'd0,  K_VALID},
            '{8'hFE, 1'b0, TYPED, 2'd1, 32'h0000_0000, K_BADLEAD, 32'd0,  K_VALID},
            '{8'h80, 1'b0, TYPED, 2'd1, 32'h0000_0000, K_BADLEAD, 32'd0,  K_VALID},
            '{8'h00, 1'b1, TYPED, 2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hC3, 1'b0, TYPED, 2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hE2, 1'b0, TYPED, 2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'h82, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hAC, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hFD, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hBF, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hC2, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'h41, 1'b0, TYPED, 2'd2, ONES,          K_BROKEN,  32'h41, K_VALID},
            '{8'hE0, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hFF, 1'b0, TYPED, 2'd2, ONES,          K_BROKEN,  32'd0,  K_BADLEAD},
            '{8'hF8, 1'b0, PRED,  2'd0, 32'd0,         K_VALID,   32'd0,  K_VALID},
            '{8'hC5, 1'b0, TYPED, 2'd1, ONES,          K_BROKEN,  32'd0,  K_VALID},
            '{8'hAA, 1'b1, TYPED, 2'd1, ONES,          K_BROKEN,  32'd0,  K_VALID}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part: typed rows push their own results, the shadow
        // decoder still steps so that its state follows the stream
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].b, dir_rows[i].e);
            n = decode_step(dir_rows[i].b, dir_rows[i].e, r0, r1);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].nres >= 2'd1)
                    push_due(dir_rows[i].cp0, dir_rows[i].k0, dir_rows[i].nres == 2'd1);
                if (dir_rows[i].nres == 2'd2)
                    push_due(dir_rows[i].cp1, dir_rows[i].k1, 1'b1);
            end
            else
            begin
                if (n >= 1)
                    code_points_due.push_back(r0);
                if (n == 2)
                    code_points_due.push_back(r1);
            end
        end
        drain();

        // random part: mostly well-formed characters, mixed with cut-short
        // sequences, raw noise and end markers
        rand_beats = 0;
        paused = 1'b0;
        while (rand_beats < RANDOM_BEATS)
        begin
            // switch between idle-heavy and back-to-back stretches
            if ($urandom_range(0, 49) == 0)
                in_gap_max = 3 * $urandom_range(0, 1);
            if ($urandom_range(0, 49) == 0)
                out_stall_max = 3 * $urandom_range(0, 1);

            burst.delete();
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                len = $urandom_range(1, 6);
                burst.push_back({1'b0, lead_for(len)});
                repeat (len - 1)
                    burst.push_back({3'b010, 6'($urandom_range(0, 63))});
            end
            else if (sel < 80)
            begin
                // sequence cut short by a non-continuation byte or the end marker
                len = $urandom_range(2, 6);
                burst.push_back({1'b0, lead_for(len)});
                repeat ($urandom_range(0, len - 2))
                    burst.push_back({3'b010, 6'($urandom_range(0, 63))});
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    burst.push_back({1'b1, b});
                else
                begin
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    burst.push_back({1'b0, b});
                end
            end
            else if (sel < 92)
                burst.push_back({1'b0, 8'($urandom_range(0, 255))});
            else
                burst.push_back({1'b1, 8'($urandom_range(0, 255))});

            foreach (burst[k])
            begin
                beat = burst[k];
                send_beat(beat[7:0], beat[8]);
                n = decode_step(beat[7:0], beat[8], r0, r1);
                if (n >= 1)
                    code_points_due.push_back(r0);
                if (n == 2)
                    code_points_due.push_back(r1);
                rand_beats++;
            end

            // one full pause partway through
            if (!paused && rand_beats > RANDOM_BEATS / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
